// ----- rtl/esc_pkg.sv -----
// Shared constants and types of the environmental sensor compensation block.
`timescale 1ns / 1ps

package esc_pkg;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 64;

    localparam int ADC_T_W = 20;
    localparam int ADC_P_W = 20;
    localparam int ADC_H_W = 16;
    localparam int TEMP_W  = 15;
    localparam int PRESS_W = 25;
    localparam int HUM_W   = 17;

    localparam int DIV_STEPS = 36;
    localparam int LATENCY   = 12 + DIV_STEPS + 4;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_CALIB_TEMP     = 3'd0,
        REG_CALIB_PRESS_LO = 3'd1,
        REG_CALIB_PRESS_HI = 3'd2,
        REG_CALIB_PRESS_P9 = 3'd3,
        REG_CALIB_HUM      = 3'd4
    } t_cfg_reg;

endpackage

// ----- rtl/esc_intf.sv -----
// Handshake interfaces for the sample, result and configuration channels.
`timescale 1ns / 1ps

interface esc_in_if;
    logic                          valid;
    logic                          ready;
    logic [esc_pkg::ADC_T_W-1:0]   adc_temperature;
    logic [esc_pkg::ADC_P_W-1:0]   adc_pressure;
    logic [esc_pkg::ADC_H_W-1:0]   adc_humidity;

    modport source (output valid, adc_temperature, adc_pressure, adc_humidity, input ready);
    modport sink (input valid, adc_temperature, adc_pressure, adc_humidity, output ready);
endinterface

interface esc_out_if;
    logic                                valid;
    logic                                ready;
    logic signed [esc_pkg::TEMP_W-1:0]   temperature_centi;
    logic [esc_pkg::PRESS_W-1:0]         pressure_q8;
    logic [esc_pkg::HUM_W-1:0]           humidity_q10;
    logic                                pressure_div_zero;

    modport source (output valid, temperature_centi, pressure_q8, humidity_q10,
                    pressure_div_zero, input ready);
    modport sink (input valid, temperature_centi, pressure_q8, humidity_q10,
                  pressure_div_zero, output ready);
endinterface

interface esc_cfg_if;
    logic                             valid;
    logic                             ready;
    logic [esc_pkg::CFG_IDX_W-1:0]    index;
    logic [esc_pkg::CFG_DATA_W-1:0]   data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

// ----- rtl/env_sensor_compensation.sv -----
// Top level: pipelined factory-calibration compensation of sensor samples.
//
//  Channel   Dir  Word contents
//  i_in      in   adc_temperature, adc_pressure, adc_humidity
//  o_res     out  temperature_centi, pressure_q8, humidity_q10, pressure_div_zero
//  i_cfg     in   index, data (calibration register write, always ready)
//
// One word enters per cycle unless the pipeline holds.
// Most of the latency is in the pressure division, one quotient bit per stage over 36 stages.
// Reset clears the calibration registers and all valid bits.
// When the result register is full and not taken, the whole pipeline holds.
`timescale 1ns / 1ps

module env_sensor_compensation (
    input logic       i_clk,
    input logic       i_rst_n,
    esc_in_if.sink    i_in,
    esc_cfg_if.sink   i_cfg,
    esc_out_if.source o_res
);
    import esc_pkg::*;

    logic [47:0] r_calib_temp;
    logic [63:0] r_calib_press_lo;
    logic [63:0] r_calib_press_hi;
    logic [15:0] r_calib_press_p9;
    logic [63:0] r_calib_hum;

    logic [LATENCY-1:0] r_vld;
    logic               en;

    logic signed [16:0] t1, p1;
    logic signed [15:0] t2, t3, p2, p3, p4, p5, p6, p7, p8, p9, h2;
    logic signed [8:0]  h3;
    logic [7:0]         h1u;
    logic signed [11:0] h4, h5;
    logic signed [7:0]  h6;

    assign t1  = $signed({1'b0, r_calib_temp[15:0]});
    assign t2  = $signed(r_calib_temp[31:16]);
    assign t3  = $signed(r_calib_temp[47:32]);
    assign p1  = $signed({1'b0, r_calib_press_lo[15:0]});
    assign p2  = $signed(r_calib_press_lo[31:16]);
    assign p3  = $signed(r_calib_press_lo[47:32]);
    assign p4  = $signed(r_calib_press_lo[63:48]);
    assign p5  = $signed(r_calib_press_hi[15:0]);
    assign p6  = $signed(r_calib_press_hi[31:16]);
    assign p7  = $signed(r_calib_press_hi[47:32]);
    assign p8  = $signed(r_calib_press_hi[63:48]);
    assign p9  = $signed(r_calib_press_p9);
    assign h1u = r_calib_hum[7:0];
    assign h2  = $signed(r_calib_hum[23:8]);
    assign h3  = $signed({1'b0, r_calib_hum[31:24]});
    assign h4  = $signed(r_calib_hum[43:32]);
    assign h5  = $signed(r_calib_hum[55:44]);
    assign h6  = $signed(r_calib_hum[63:56]);

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_calib_temp     <= '0;
            r_calib_press_lo <= '0;
            r_calib_press_hi <= '0;
            r_calib_press_p9 <= '0;
            r_calib_hum      <= '0;
        end else if (i_cfg.valid) begin
            unique case (t_cfg_reg'(i_cfg.index))
                REG_CALIB_TEMP:     r_calib_temp     <= i_cfg.data[47:0];
                REG_CALIB_PRESS_LO: r_calib_press_lo <= i_cfg.data;
                REG_CALIB_PRESS_HI: r_calib_press_hi <= i_cfg.data;
                REG_CALIB_PRESS_P9: r_calib_press_p9 <= i_cfg.data[15:0];
                REG_CALIB_HUM:      r_calib_hum      <= i_cfg.data;
                default: begin
                end
            endcase
        end
    end

    assign en         = !r_vld[LATENCY-1] || o_res.ready;
    assign i_in.ready = en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[LATENCY-2:0], i_in.valid};
        end
    end

    // Stage 1: temperature differences and first products.
    logic signed [17:0] c1_d1;
    logic signed [16:0] c1_d2;
    logic signed [33:0] r1_d1t2, r1_d2sq;
    logic [19:0]        r1_ap;
    logic [15:0]        r1_ah;

    assign c1_d1 = $signed({1'b0, i_in.adc_temperature[19:3]}) - $signed({t1, 1'b0});
    assign c1_d2 = $signed({1'b0, i_in.adc_temperature[19:4]}) - t1;

    // Stage 2: fine temperature.
    logic signed [21:0] c2_b;
    logic signed [37:0] c2_bt3, c2_tf;
    logic signed [23:0] r2_tf;
    logic [19:0]        r2_ap;
    logic [15:0]        r2_ah;

    assign c2_b   = $signed(r1_d2sq[33:12]);
    assign c2_bt3 = c2_b * t3;
    assign c2_tf  = (r1_d1t2 >>> 11) + (c2_bt3 >>> 14);

    // Stage 3: temperature output, pressure and humidity first products.
    logic signed [27:0] c3_t5, c3_tc;
    logic signed [14:0] c3_temp;
    logic signed [24:0] c3_e, c3_h;
    logic signed [49:0] c3_e2;
    logic [46:0]        r3_e2;
    logic signed [40:0] r3_ep5, r3_ep2;
    logic signed [36:0] r3_h5h;
    logic signed [32:0] r3_hh6;
    logic signed [33:0] r3_hh3;
    logic [19:0]        r3_ap;
    logic [15:0]        r3_ah;
    logic signed [14:0] r_tp [0:8];

    assign c3_t5   = r2_tf * 28'sd5 + 28'sd128;
    assign c3_tc   = c3_t5 >>> 8;
    assign c3_temp = (c3_tc < -28'sd4000) ? -15'sd4000 :
                     (c3_tc > 28'sd8500) ? 15'sd8500 : c3_tc[14:0];
    assign c3_e    = r2_tf - 25'sd128000;
    assign c3_h    = r2_tf - 25'sd76800;
    assign c3_e2   = c3_e * c3_e;

    // Stage 4.
    logic signed [40:0] r4_e2p6_l, r4_e2p3_l;
    logic signed [39:0] r4_e2p6_h, r4_e2p3_h;
    logic signed [40:0] r4_ep5, r4_ep2;
    logic signed [38:0] c4_xs;
    logic signed [23:0] r4_xa;
    logic signed [22:0] c4_a;
    logic signed [33:0] c4_bs;
    logic signed [23:0] c4_b;
    logic signed [46:0] r4_hp;
    logic [19:0]        r4_ap;

    assign c4_xs = $signed({8'd0, r3_ah, 14'd0}) - (h4 <<< 20) - r3_h5h + 39'sd16384;
    assign c4_a  = $signed(r3_hh6[32:10]);
    assign c4_bs = (r3_hh3 >>> 11) + 34'sd32768;
    assign c4_b  = c4_bs[23:0];

    // Stage 5.
    logic signed [63:0] r5_e2p6, r5_e2p3;
    logic signed [40:0] r5_ep5, r5_ep2;
    logic signed [46:0] c5_ins;
    logic signed [36:0] c5_in;
    logic signed [35:0] r5_ih_l;
    logic signed [33:0] r5_ih_h;
    logic signed [23:0] r5_xa;
    logic [19:0]        r5_ap;

    assign c5_ins = (r4_hp >>> 10) + 47'sd2097152;
    assign c5_in  = c5_ins[36:0];

    // Stage 6.
    logic signed [63:0] c6_w, c6_a;
    logic signed [63:0] r6_q;
    logic signed [55:0] r6_a;
    logic signed [53:0] c6_xbs, c6_xb;
    logic signed [38:0] r6_xb;
    logic signed [23:0] r6_xa;
    logic [19:0]        r6_ap;

    assign c6_w   = (r5_e2p3 >>> 8) + (r5_ep2 <<< 12);
    assign c6_a   = c6_w + 64'sh0000_8000_0000_0000;
    assign c6_xbs = (r5_ih_h <<< 19) + r5_ih_l + 54'sd8192;
    assign c6_xb  = c6_xbs >>> 14;

    // Stage 7.
    logic signed [55:0] c7_hiw;
    logic signed [38:0] c7_hi;
    logic [20:0]        c7_ad;
    logic signed [36:0] r7_hp_l, r7_hp_h;
    logic [32:0]        r7_lop;
    logic signed [63:0] r7_m;
    logic signed [44:0] r7_xv_l;
    logic signed [42:0] r7_xv_h;

    assign c7_hiw = r6_a >>> 17;
    assign c7_hi  = c7_hiw[38:0];
    assign c7_ad  = 21'd1048576 - {1'b0, r6_ap};

    // Stage 8.
    logic signed [55:0] c8_ds, c8_dsh;
    logic signed [39:0] r8_den;
    logic signed [63:0] r8_m;
    logic signed [63:0] c8_vs;
    logic signed [41:0] c8_v, r8_v;

    assign c8_ds  = (r7_hp_h <<< 19) + r7_hp_l + $signed({23'd0, r7_lop[32:17]});
    assign c8_dsh = c8_ds >>> 16;
    assign c8_vs  = (r7_xv_h <<< 20) + r7_xv_l;
    assign c8_v   = (c8_vs > 64'sd1099511627776) ? 42'sd1099511627776 :
                    (c8_vs < -64'sd1099511627776) ? -42'sd1099511627776 : c8_vs[41:0];

    // Stage 9.
    logic signed [63:0] c9_um;
    logic signed [39:0] c9_ud;
    logic signed [26:0] c9_z;
    logic signed [53:0] c9_zz;
    logic [62:0]        r9_um;
    logic [38:0]        r9_ud;
    logic               r9_neg, r9_zero;
    logic [50:0]        r9_zz;
    logic signed [41:0] r9_v;

    assign c9_um = r8_m[63] ? -r8_m : r8_m;
    assign c9_ud = r8_den[39] ? -r8_den : r8_den;
    assign c9_z  = $signed(r8_v[41:15]);
    assign c9_zz = c9_z * c9_z;

    // Stage 10.
    logic [67:0]        r10_n25;
    logic [29:0]        r10_zh_l, r10_zh_h;
    logic signed [41:0] r10_v;
    logic [38:0]        r10_ud;
    logic               r10_neg, r10_zero;

    // Stage 11.
    logic [51:0]        c11_zh;
    logic signed [52:0] c11_v;
    logic [74:0]        r11_n;
    logic [16:0]        r11_hum;
    logic [38:0]        r11_ud;
    logic               r11_neg, r11_zero;

    assign c11_zh = {r10_zh_h, 22'd0} + {22'd0, r10_zh_l};
    assign c11_v  = r10_v - $signed({1'b0, c11_zh[51:4]});

    // Divider stages.
    logic [38:0]        r_rem  [0:DIV_STEPS];
    logic [35:0]        r_nlo  [0:DIV_STEPS];
    logic [35:0]        r_qt   [0:DIV_STEPS];
    logic [38:0]        r_dud  [0:DIV_STEPS];
    logic               r_dneg [0:DIV_STEPS];
    logic               r_dzero[0:DIV_STEPS];
    logic               r_dsat [0:DIV_STEPS];
    logic signed [14:0] r_dtemp[0:DIV_STEPS];
    logic [16:0]        r_dhum [0:DIV_STEPS];

    // Post-division stages.
    logic signed [37:0] cA_mag, cA_p;
    logic signed [24:0] cA_s;
    logic signed [49:0] cA_ss;
    logic [46:0]        rA_ss;
    logic signed [35:0] rA_py_l;
    logic signed [34:0] rA_py_h;
    logic signed [37:0] rA_p, rB_p;
    logic               rA_zero, rB_zero, rC_zero;
    logic signed [14:0] rA_temp, rB_temp, rC_temp;
    logic [16:0]        rA_hum, rB_hum, rC_hum;
    logic signed [40:0] rB_sp_l;
    logic signed [39:0] rB_sp_h;
    logic signed [54:0] cB_ys, cB_y;
    logic signed [35:0] rB_y;
    logic signed [63:0] cC_xs, cC_x;
    logic signed [38:0] rC_x, rC_py;
    logic signed [39:0] cO_sum, cO_pr;
    logic [24:0]        cO_press;

    assign cA_mag = r_dsat[DIV_STEPS] ? 38'sd68719476736 : $signed({2'b0, r_qt[DIV_STEPS]});
    assign cA_p   = r_dneg[DIV_STEPS] ? -cA_mag : cA_mag;
    assign cA_s   = $signed(cA_p[37:13]);
    assign cA_ss  = cA_s * cA_s;
    assign cB_ys  = (rA_py_h <<< 19) + rA_py_l;
    assign cB_y   = cB_ys >>> 19;
    assign cC_xs  = (rB_sp_h <<< 24) + rB_sp_l;
    assign cC_x   = cC_xs >>> 25;
    assign cO_sum = rC_py + rC_x;
    assign cO_pr  = (cO_sum >>> 8) + (p7 <<< 4);
    assign cO_press = (cO_pr < 40'sd0) ? 25'd0 :
                      (cO_pr > 40'sd33554431) ? 25'h1FFFFFF : cO_pr[24:0];

    logic signed [14:0] r_o_temp;
    logic [24:0]        r_o_press;
    logic [16:0]        r_o_hum;
    logic               r_o_dz;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r1_d1t2 <= c1_d1 * t2;
            r1_d2sq <= c1_d2 * c1_d2;
            r1_ap   <= i_in.adc_pressure;
            r1_ah   <= i_in.adc_humidity;

            r2_tf <= c2_tf[23:0];
            r2_ap <= r1_ap;
            r2_ah <= r1_ah;

            r_tp[0] <= c3_temp;
            r3_e2   <= c3_e2[46:0];
            r3_ep5  <= c3_e * p5;
            r3_ep2  <= c3_e * p2;
            r3_h5h  <= h5 * c3_h;
            r3_hh6  <= c3_h * h6;
            r3_hh3  <= c3_h * h3;
            r3_ap   <= r2_ap;
            r3_ah   <= r2_ah;

            r4_e2p6_l <= $signed({1'b0, r3_e2[23:0]}) * p6;
            r4_e2p6_h <= $signed({1'b0, r3_e2[46:24]}) * p6;
            r4_e2p3_l <= $signed({1'b0, r3_e2[23:0]}) * p3;
            r4_e2p3_h <= $signed({1'b0, r3_e2[46:24]}) * p3;
            r4_ep5    <= r3_ep5;
            r4_ep2    <= r3_ep2;
            r4_xa     <= c4_xs[38:15];
            r4_hp     <= c4_a * c4_b;
            r4_ap     <= r3_ap;

            r5_e2p6 <= (r4_e2p6_h <<< 24) + r4_e2p6_l;
            r5_e2p3 <= (r4_e2p3_h <<< 24) + r4_e2p3_l;
            r5_ep5  <= r4_ep5;
            r5_ep2  <= r4_ep2;
            r5_ih_l <= $signed({1'b0, c5_in[18:0]}) * h2;
            r5_ih_h <= $signed(c5_in[36:19]) * h2;
            r5_xa   <= r4_xa;
            r5_ap   <= r4_ap;

            r6_q  <= r5_e2p6 + (r5_ep5 <<< 17) + (p4 <<< 35);
            r6_a  <= c6_a[55:0];
            r6_xb <= c6_xb[38:0];
            r6_xa <= r5_xa;
            r6_ap <= r5_ap;

            r7_hp_l <= $signed({1'b0, c7_hi[18:0]}) * p1;
            r7_hp_h <= $signed(c7_hi[38:19]) * p1;
            r7_lop  <= r6_a[16:0] * r_calib_press_lo[15:0];
            r7_m    <= $signed({1'b0, c7_ad, 31'd0}) - r6_q;
            r7_xv_l <= r6_xa * $signed({1'b0, r6_xb[19:0]});
            r7_xv_h <= r6_xa * $signed(r6_xb[38:20]);

            r8_den <= c8_dsh[39:0];
            r8_m   <= r7_m;
            r8_v   <= c8_v;

            r9_um   <= c9_um[62:0];
            r9_ud   <= c9_ud[38:0];
            r9_neg  <= r8_m[63] ^ r8_den[39];
            r9_zero <= (r8_den == 40'sd0);
            r9_zz   <= c9_zz[50:0];
            r9_v    <= r8_v;

            r10_n25  <= {1'b0, r9_um, 4'd0} + {2'd0, r9_um, 3'd0} + {5'd0, r9_um};
            r10_zh_l <= r9_zz[28:7] * h1u;
            r10_zh_h <= r9_zz[50:29] * h1u;
            r10_v    <= r9_v;
            r10_ud   <= r9_ud;
            r10_neg  <= r9_neg;
            r10_zero <= r9_zero;

            r11_n    <= {r10_n25, 7'd0} - {6'd0, r10_n25, 1'b0} - {7'd0, r10_n25};
            r11_hum  <= (c11_v < 53'sd0) ? 17'd0 :
                        (c11_v > 53'sd419430400) ? 17'd102400 : c11_v[28:12];
            r11_ud   <= r10_ud;
            r11_neg  <= r10_neg;
            r11_zero <= r10_zero;

            for (int k = 1; k <= 8; k++) begin
                r_tp[k] <= r_tp[k-1];
            end

            r_rem[0]   <= r11_n[74:36];
            r_nlo[0]   <= r11_n[35:0];
            r_qt[0]    <= '0;
            r_dud[0]   <= r11_ud;
            r_dneg[0]  <= r11_neg;
            r_dzero[0] <= r11_zero;
            r_dsat[0]  <= (r11_n[74:36] >= r11_ud);
            r_dtemp[0] <= r_tp[8];
            r_dhum[0]  <= r11_hum;

            rA_ss   <= cA_ss[46:0];
            rA_py_l <= $signed({1'b0, cA_p[18:0]}) * p8;
            rA_py_h <= $signed(cA_p[37:19]) * p8;
            rA_p    <= cA_p;
            rA_zero <= r_dzero[DIV_STEPS];
            rA_temp <= r_dtemp[DIV_STEPS];
            rA_hum  <= r_dhum[DIV_STEPS];

            rB_sp_l <= $signed({1'b0, rA_ss[23:0]}) * p9;
            rB_sp_h <= $signed({1'b0, rA_ss[46:24]}) * p9;
            rB_y    <= cB_y[35:0];
            rB_p    <= rA_p;
            rB_zero <= rA_zero;
            rB_temp <= rA_temp;
            rB_hum  <= rA_hum;

            rC_x    <= cC_x[38:0];
            rC_py   <= rB_p + rB_y;
            rC_zero <= rB_zero;
            rC_temp <= rB_temp;
            rC_hum  <= rB_hum;

            r_o_temp  <= rC_temp;
            r_o_hum   <= rC_hum;
            r_o_dz    <= rC_zero;
            r_o_press <= rC_zero ? 25'd0 : cO_press;
        end
    end

    for (genvar j = 1; j <= DIV_STEPS; j++) begin : g_div
        logic [39:0] rem2;
        logic [40:0] diff;
        logic        ge;

        assign rem2 = {r_rem[j-1], r_nlo[j-1][35]};
        assign diff = {1'b0, rem2} - {2'd0, r_dud[j-1]};
        assign ge   = !diff[40];

        always_ff @(posedge i_clk) begin
            if (en) begin
                r_rem[j]   <= ge ? diff[38:0] : rem2[38:0];
                r_nlo[j]   <= {r_nlo[j-1][34:0], 1'b0};
                r_qt[j]    <= {r_qt[j-1][34:0], ge};
                r_dud[j]   <= r_dud[j-1];
                r_dneg[j]  <= r_dneg[j-1];
                r_dzero[j] <= r_dzero[j-1];
                r_dsat[j]  <= r_dsat[j-1];
                r_dtemp[j] <= r_dtemp[j-1];
                r_dhum[j]  <= r_dhum[j-1];
            end
        end
    end

    assign o_res.valid             = r_vld[LATENCY-1];
    assign o_res.temperature_centi = r_o_temp;
    assign o_res.pressure_q8       = r_o_press;
    assign o_res.humidity_q10      = r_o_hum;
    assign o_res.pressure_div_zero = r_o_dz;

    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !en |=> $stable(r_vld))
        else $error("pipeline valid bits moved during a stall");

    a_div_zero_press: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid && o_res.pressure_div_zero |-> o_res.pressure_q8 == 25'd0)
        else $error("pressure not forced to zero on zero divisor");

    a_ranges: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid |-> o_res.humidity_q10 <= 17'd102400 &&
            o_res.temperature_centi >= -15'sd4000 && o_res.temperature_centi <= 15'sd8500)
        else $error("compensated value out of range");

endmodule

// ----- tb/testbench.sv -----
// Self-checking testbench for env_sensor_compensation: directed and random samples checked against a predictor.
`timescale 1ns / 1ps

module testbench;
    import esc_pkg::*;

    typedef struct {
        logic [ADC_T_W-1:0] t_code;
        logic [ADC_P_W-1:0] p_code;
        logic [ADC_H_W-1:0] h_code;
    } sample_t;

    typedef struct {
        logic signed [TEMP_W-1:0] temp;
        logic [PRESS_W-1:0]       press;
        logic [HUM_W-1:0]         hum;
        logic                     div_zero;
    } comp_t;

    localparam longint CYCLE_LIMIT = 400000;
    localparam longint PQ_SAT      = 64'sd68719476736;
    localparam longint HUM_SAT     = 64'sd1099511627776;

    logic i_clk;
    logic i_rst_n;

    esc_in_if  in_if ();
    esc_cfg_if cfg_if ();
    esc_out_if res_if ();

    env_sensor_compensation dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .i_cfg   (cfg_if),
        .o_res   (res_if)
    );

    logic [47:0] cal_temp;
    logic [63:0] cal_press_lo;
    logic [63:0] cal_press_hi;
    logic [15:0] cal_press_p9;
    logic [63:0] cal_hum;

    sample_t pending_samples[$];
    comp_t   expected_results[$];
    sample_t next_sample;
    comp_t   got;
    comp_t   want;

    logic in_fire;
    logic calm;
    logic rx_hold_req;
    logic rx_hold_done;
    int   rx_hold_cnt;
    int   errors;
    int   n_accepted;
    int   n_results;
    int   n_div_zero;
    int   n_phases;
    longint cycles;

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    function automatic longint clampl(input longint x, input longint lo, input longint hi);
        return x < lo ? lo : (x > hi ? hi : x);
    endfunction

    function automatic comp_t compensate(input sample_t smp);
        comp_t  r;
        longint at, ap, ah;
        longint t1, t2, t3, p1, p2, p3, p4, p5, p6, p7, p8, p9;
        longint h1, h2, h3, h4, h5, h6;
        longint d1, d2, tf, e, q, w, a, hi, lo, den, m, pval, s, x, y, pres;
        longint h, xa, xb, inner, v, z;
        longint unsigned um, ud, q0, r0, mag;
        logic   neg;
        at = longint'(smp.t_code);
        ap = longint'(smp.p_code);
        ah = longint'(smp.h_code);
        t1 = longint'(cal_temp[15:0]);
        t2 = longint'($signed(cal_temp[31:16]));
        t3 = longint'($signed(cal_temp[47:32]));
        p1 = longint'(cal_press_lo[15:0]);
        p2 = longint'($signed(cal_press_lo[31:16]));
        p3 = longint'($signed(cal_press_lo[47:32]));
        p4 = longint'($signed(cal_press_lo[63:48]));
        p5 = longint'($signed(cal_press_hi[15:0]));
        p6 = longint'($signed(cal_press_hi[31:16]));
        p7 = longint'($signed(cal_press_hi[47:32]));
        p8 = longint'($signed(cal_press_hi[63:48]));
        p9 = longint'($signed(cal_press_p9));
        h1 = longint'(cal_hum[7:0]);
        h2 = longint'($signed(cal_hum[23:8]));
        h3 = longint'(cal_hum[31:24]);
        h4 = longint'($signed(cal_hum[43:32]));
        h5 = longint'($signed(cal_hum[55:44]));
        h6 = longint'($signed(cal_hum[63:56]));

        d1 = (at >>> 3) - t1 * 2;
        d2 = (at >>> 4) - t1;
        tf = ((d1 * t2) >>> 11) + ((((d2 * d2) >>> 12) * t3) >>> 14);
        r.temp = TEMP_W'(clampl((tf * 5 + 128) >>> 8, -4000, 8500));

        e = tf - 128000;
        q = e * e * p6 + e * p5 * 131072 + p4 * 64'sd34359738368;
        w = ((e * e * p3) >>> 8) + e * p2 * 4096;
        a = 64'sd140737488355328 + w;
        hi = a >>> 17;
        lo = a - hi * 131072;
        den = (hi * p1 + ((lo * p1) >>> 17)) >>> 16;
        if (den == 0) begin
            r.div_zero = 1'b1;
            pres = 0;
        end else begin
            r.div_zero = 1'b0;
            m = (1048576 - ap) * 64'sd2147483648 - q;
            neg = (m < 0) != (den < 0);
            um = longint'(m < 0 ? -m : m);
            ud = longint'(den < 0 ? -den : den);
            q0 = um / ud;
            r0 = um % ud;
            if (q0 >= PQ_SAT) begin
                mag = PQ_SAT;
            end else begin
                mag = q0 * 3125 + (r0 * 3125) / ud;
            end
            if (mag > PQ_SAT) begin
                mag = PQ_SAT;
            end
            pval = neg ? -longint'(mag) : longint'(mag);
            s = pval >>> 13;
            x = (p9 * s * s) >>> 25;
            y = (p8 * pval) >>> 19;
            pres = clampl(((pval + x + y) >>> 8) + p7 * 16, 0, 33554431);
        end
        r.press = PRESS_W'(pres);

        h = tf - 76800;
        xa = (ah * 16384 - h4 * 1048576 - h5 * h + 16384) >>> 15;
        inner = ((((h * h6) >>> 10) * (((h * h3) >>> 11) + 32768)) >>> 10) + 2097152;
        xb = (inner * h2 + 8192) >>> 14;
        v = clampl(xa * xb, -HUM_SAT, HUM_SAT);
        z = v >>> 15;
        v = v - ((((z * z) >>> 7) * h1) >>> 4);
        v = clampl(v, 0, 419430400) >>> 12;
        r.hum = HUM_W'(v);
        return r;
    endfunction

    task automatic report_mismatch(input string what, input longint got_v, input longint want_v);
        $display("MISMATCH %s: got %0d expected %0d (result %0d)", what, got_v, want_v,
                 n_results);
        errors++;
    endtask

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles, %0d results outstanding", cycles,
                     expected_results.size());
            $display("TEST FAILED");
            $finish;
        end
    end

    // Sample-side driver: a word is held until accepted.
    always @(negedge i_clk) begin
        if (i_rst_n && (!in_if.valid || in_fire)) begin
            if (pending_samples.size() > 0 && (calm || $urandom_range(99) >= 21)) begin
                next_sample = pending_samples.pop_front();
                in_if.adc_temperature <= next_sample.t_code;
                in_if.adc_pressure    <= next_sample.p_code;
                in_if.adc_humidity    <= next_sample.h_code;
                in_if.valid           <= 1'b1;
            end else begin
                in_if.valid <= 1'b0;
            end
        end
    end

    // Result-side ready, with one long hold-off on request.
    always @(negedge i_clk) begin
        if (rx_hold_req && !rx_hold_done) begin
            res_if.ready <= 1'b0;
            rx_hold_cnt++;
            if (rx_hold_cnt >= 400) begin
                rx_hold_done <= 1'b1;
            end
        end else begin
            res_if.ready <= calm || ($urandom_range(99) >= 21);
        end
    end

    always @(posedge i_clk) begin
        in_fire <= in_if.valid && in_if.ready;
        if (in_if.valid && in_if.ready) begin
            next_sample.t_code = in_if.adc_temperature;
            next_sample.p_code = in_if.adc_pressure;
            next_sample.h_code = in_if.adc_humidity;
            expected_results.push_back(compensate(next_sample));
            n_accepted++;
        end
        if (res_if.valid && res_if.ready) begin
            got.temp     = res_if.temperature_centi;
            got.press    = res_if.pressure_q8;
            got.hum      = res_if.humidity_q10;
            got.div_zero = res_if.pressure_div_zero;
            if (expected_results.size() == 0) begin
                report_mismatch("unexpected word", 1, 0);
            end else begin
                want = expected_results.pop_front();
                if (got.temp !== want.temp)
                    report_mismatch("temperature_centi", got.temp, want.temp);
                if (got.press !== want.press)
                    report_mismatch("pressure_q8", got.press, want.press);
                if (got.hum !== want.hum)
                    report_mismatch("humidity_q10", got.hum, want.hum);
                if (got.div_zero !== want.div_zero)
                    report_mismatch("pressure_div_zero", got.div_zero, want.div_zero);
                if (want.div_zero) n_div_zero++;
            end
            n_results++;
        end
    end

    task automatic write_reg(input t_cfg_reg idx, input logic [63:0] value);
        @(negedge i_clk);
        cfg_if.valid <= 1'b1;
        cfg_if.index <= idx;
        cfg_if.data  <= value;
        @(posedge i_clk);
        while (!cfg_if.ready) @(posedge i_clk);
        case (idx)
            REG_CALIB_TEMP:     cal_temp     = value[47:0];
            REG_CALIB_PRESS_LO: cal_press_lo = value;
            REG_CALIB_PRESS_HI: cal_press_hi = value;
            REG_CALIB_PRESS_P9: cal_press_p9 = value[15:0];
            REG_CALIB_HUM:      cal_hum      = value;
            default: ;
        endcase
        @(negedge i_clk);
        cfg_if.valid <= 1'b0;
    endtask

    task automatic load_calibration(input logic [63:0] ct, input logic [63:0] plo,
                                    input logic [63:0] phi, input logic [63:0] p9,
                                    input logic [63:0] ch);
        write_reg(REG_CALIB_TEMP, ct);
        write_reg(REG_CALIB_PRESS_LO, plo);
        write_reg(REG_CALIB_PRESS_HI, phi);
        write_reg(REG_CALIB_PRESS_P9, p9);
        write_reg(REG_CALIB_HUM, ch);
        n_phases++;
    endtask

    task automatic wait_drained();
        while (pending_samples.size() != 0 || in_if.valid || expected_results.size() != 0)
            @(posedge i_clk);
        repeat (LATENCY + 4) @(posedge i_clk);
    endtask

    task automatic add_sample(input logic [19:0] t, input logic [19:0] p, input logic [15:0] h);
        sample_t smp;
        smp.t_code = t;
        smp.p_code = p;
        smp.h_code = h;
        pending_samples.push_back(smp);
    endtask

    task automatic add_random_samples(input int count);
        for (int k = 0; k < count; k++) begin
            if ($urandom_range(99) < 75)
                add_sample($urandom_range(650000, 350000), $urandom_range(500000, 200000),
                           $urandom_range(45000, 15000));
            else
                add_sample($urandom, $urandom, $urandom);
        end
    endtask

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    initial begin
        logic [63:0] typ_t, typ_plo, typ_phi, typ_p9, typ_h;
        typ_t   = {16'h0000, 16'hFC18, 16'd26435, 16'd27504};
        typ_plo = {16'd2855, 16'd3024, 16'hD643, 16'd36477};
        typ_phi = {16'hC6F8, 16'd15500, 16'hFFF9, 16'd140};
        typ_p9  = 64'd6000;
        typ_h   = {8'd30, 12'd50, 12'd324, 8'd0, 16'd362, 8'd75};
        i_rst_n = 1'b0;
        in_if.valid = 1'b0;
        in_if.adc_temperature = '0;
        in_if.adc_pressure = '0;
        in_if.adc_humidity = '0;
        cfg_if.valid = 1'b0;
        cfg_if.index = '0;
        cfg_if.data = '0;
        res_if.ready = 1'b0;
        cal_temp = '0;
        cal_press_lo = '0;
        cal_press_hi = '0;
        cal_press_p9 = '0;
        cal_hum = '0;
        in_fire = 1'b0;
        calm = 1'b0;
        rx_hold_req = 1'b0;
        rx_hold_done = 1'b0;
        rx_hold_cnt = 0;
        errors = 0;
        n_accepted = 0;
        n_results = 0;
        n_div_zero = 0;
        n_phases = 0;
        cycles = 0;
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Reset calibration is all zero, so the pressure divisor is zero.
        add_sample('0, '0, '0);
        add_sample('1, '1, '1);
        add_sample(20'd519888, 20'd415148, 16'd30000);
        wait_drained();

        load_calibration(typ_t, typ_plo, typ_phi, typ_p9, typ_h);
        add_sample('0, 20'd415148, 16'd30000);
        add_sample('1, 20'd415148, 16'd30000);
        add_sample(20'd519888, '0, 16'd30000);
        add_sample(20'd519888, '1, 16'd30000);
        add_sample(20'd519888, 20'd415148, '0);
        add_sample(20'd519888, 20'd415148, '1);
        add_sample(20'd519888, 20'd415148, 16'd30000);
        add_sample(20'd300000, 20'd600000, 16'd50000);
        add_sample(20'd700000, 20'd100000, 16'd10000);
        add_sample(20'hAAAAA, 20'h55555, 16'hAAAA);
        add_sample(20'h55555, 20'hAAAAA, 16'h5555);
        add_sample('0, '0, '0);
        add_sample('1, '1, '1);
        wait_drained();

        load_calibration('1, '1, '1, '1, '1);
        add_random_samples(40);
        wait_drained();
        load_calibration(64'h7FFF_7FFF_FFFF, 64'h7FFF_7FFF_7FFF_FFFF, 64'h7FFF_7FFF_7FFF_7FFF,
                         64'h7FFF, 64'h7F7F_F7FF_FF7F_FFFF);
        add_random_samples(40);
        wait_drained();
        load_calibration(64'h8000_8000_0000, 64'h8000_8000_8000_0001, 64'h8000_8000_8000_8000,
                         64'h8000, 64'h8080_0800_0080_0000);
        add_random_samples(40);
        wait_drained();

        for (int ph = 0; ph < 8; ph++) begin
            if (ph % 2 == 0) begin
                load_calibration(typ_t ^ {$urandom_range(255), $urandom_range(255)},
                                 typ_plo ^ {$urandom_range(255), $urandom_range(255)},
                                 typ_phi ^ {$urandom_range(255), $urandom_range(255)},
                                 typ_p9 ^ $urandom_range(255),
                                 typ_h ^ {$urandom_range(15), $urandom_range(255)});
            end else begin
                load_calibration(rand64(), rand64(), rand64(), rand64(), rand64());
            end
            calm = (ph == 2);
            rx_hold_req = (ph == 4);
            add_random_samples(210);
            wait_drained();
        end
        calm = 1'b0;

        $display("Ran %0d samples over %0d calibration settings, %0d results checked,",
                 n_accepted, n_phases + 1, n_results);
        $display("%0d of them with a zero pressure divisor.", n_div_zero);
        if (errors == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("%0d mismatches", errors);
            $display("TEST FAILED");
        end
        $finish;
    end
endmodule

// ----- sim.f -----
rtl/esc_pkg.sv
rtl/esc_intf.sv
rtl/env_sensor_compensation.sv
tb/testbench.sv
